/* hdl/scl_pkg.sv */
package scl_pkg;

  // Largest window in samples; the ring holds one segment fewer.
  localparam int unsigned MAX_WINDOW = 64;
  localparam int unsigned RING_DEPTH = MAX_WINDOW - 1;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned WIN_W    = 7;
  localparam int unsigned TSQ_W    = 34;
  localparam int unsigned DIFF_W   = SAMPLE_W + 1;
  localparam int unsigned RAD_W    = 36;
  localparam int unsigned SEG_W    = RAD_W / 2;
  localparam int unsigned SUM_W    = 24;
  localparam int unsigned STEP_W   = $clog2(SEG_W);

  localparam logic [WIN_W-1:0] WIN_MIN   = WIN_W'(2);
  localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(MAX_WINDOW);
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(33);

  // Configuration register indexes
  localparam logic CFG_WINDOW_LEN   = 1'b0;
  localparam logic CFG_TIME_STEP_SQ = 1'b1;

  typedef struct packed {
    logic load_in;
    logic diff;
    logic sqrt_start;
    logic update;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic sqrt_done;
  } status_t;

endpackage

/* hdl/scl_isqrt.sv */
module scl_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [scl_pkg::RAD_W-1:0]     radicand,
  output logic                          done,
  output logic [scl_pkg::SEG_W-1:0]     root
);

  // Restoring square root, one result bit per cycle.
  logic [scl_pkg::RAD_W-1:0]  rad;
  logic [scl_pkg::SEG_W+1:0]  rem;
  logic [scl_pkg::STEP_W-1:0] step;
  logic                       active;

  logic [scl_pkg::SEG_W+3:0]  rem_shift;
  logic [scl_pkg::SEG_W+3:0]  trial;
  logic [scl_pkg::SEG_W+1:0]  rem_next;
  logic [scl_pkg::SEG_W-1:0]  root_next;
  logic                       last_step;

  assign rem_shift = {rem, rad[scl_pkg::RAD_W-1 -: 2]};
  assign trial     = {2'b00, root, 2'b01};
  assign last_step = (step == scl_pkg::STEP_W'(scl_pkg::SEG_W - 1));

  always_comb begin
    if (rem_shift >= trial) begin
      rem_next  = (scl_pkg::SEG_W+2)'(rem_shift - trial);
      root_next = {root[scl_pkg::SEG_W-2:0], 1'b1};
    end else begin
      rem_next  = (scl_pkg::SEG_W+2)'(rem_shift);
      root_next = {root[scl_pkg::SEG_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else if (start) begin
      active <= 1'b1;
      done   <= 1'b0;
      step   <= '0;
    end else if (active) begin
      step <= step + 1'b1;
      if (last_step) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (active) begin
      rad  <= {rad[scl_pkg::RAD_W-3:0], 2'b00};
      rem  <= rem_next;
      root <= root_next;
    end
  end

endmodule

/* hdl/scl_datapath.sv */
module scl_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [scl_pkg::TSQ_W-1:0]      cfg_data,
  input  logic [scl_pkg::SAMPLE_W-1:0]   s_tdata,
  input  scl_pkg::cmd_t                  cmd,
  output scl_pkg::status_t               status,
  output logic [scl_pkg::SUM_W-1:0]      m_tdata,
  output logic                           m_tuser
);

  logic [scl_pkg::WIN_W-1:0]    window_len;
  logic [scl_pkg::TSQ_W-1:0]    time_step_sq;
  logic [scl_pkg::SAMPLE_W-1:0] previous_sample;
  logic [scl_pkg::SAMPLE_W-1:0] cur_sample;
  logic [scl_pkg::SUM_W-1:0]    running_sum;
  logic [scl_pkg::PTR_W-1:0]    ring_pointer;
  logic [scl_pkg::WIN_W-1:0]    fill_count;
  logic [scl_pkg::DIFF_W-1:0]   abs_diff;
  logic [scl_pkg::SEG_W-1:0]    old_seg;

  logic [scl_pkg::SEG_W-1:0]    segment_ring [scl_pkg::RING_DEPTH];

  logic [scl_pkg::WIN_W-1:0]    cfg_window;
  logic [scl_pkg::WIN_W-1:0]    ring_len;
  logic [scl_pkg::PTR_W-1:0]    ptr_eff;
  logic [scl_pkg::WIN_W-1:0]    ptr_inc;
  logic [scl_pkg::DIFF_W-1:0]   diff;
  logic [2*scl_pkg::DIFF_W-1:0] diff_sq;
  logic [scl_pkg::RAD_W-1:0]    radicand;
  logic [scl_pkg::SEG_W-1:0]    seg;
  logic                         sqrt_done;
  logic                         ring_full;
  logic [scl_pkg::WIN_W-1:0]    fill_next;
  logic                         win_ready;

  // Window clamp on write
  always_comb begin
    if (cfg_data[scl_pkg::WIN_W-1:0] < scl_pkg::WIN_MIN) begin
      cfg_window = scl_pkg::WIN_MIN;
    end else if (cfg_data[scl_pkg::WIN_W-1:0] > scl_pkg::WIN_MAX) begin
      cfg_window = scl_pkg::WIN_MAX;
    end else begin
      cfg_window = cfg_data[scl_pkg::WIN_W-1:0];
    end
  end

  assign ring_len  = window_len - 1'b1;
  assign ptr_eff   = ({1'b0, ring_pointer} >= ring_len) ? '0 : ring_pointer;
  assign ptr_inc   = {1'b0, ptr_eff} + 1'b1;
  assign ring_full = (fill_count >= window_len);

  assign diff = {cur_sample[scl_pkg::SAMPLE_W-1], cur_sample}
              - {previous_sample[scl_pkg::SAMPLE_W-1], previous_sample};
  assign diff_sq  = abs_diff * abs_diff;
  assign radicand = scl_pkg::RAD_W'(time_step_sq) + scl_pkg::RAD_W'(diff_sq);

  assign fill_next = ring_full ? fill_count : fill_count + 1'b1;
  assign win_ready = (fill_next >= window_len);

  assign status.first     = (fill_count == '0);
  assign status.sqrt_done = sqrt_done;

  scl_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (seg)
  );

  // Config and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len      <= scl_pkg::WIN_RESET;
      time_step_sq    <= '0;
      previous_sample <= '0;
      running_sum     <= '0;
      ring_pointer    <= '0;
      fill_count      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == scl_pkg::CFG_WINDOW_LEN) begin
        window_len      <= cfg_window;
        previous_sample <= '0;
        running_sum     <= '0;
        ring_pointer    <= '0;
        fill_count      <= '0;
      end else begin
        time_step_sq <= cfg_data;
      end
    end else begin
      if (cmd.update) begin
        if (ring_full) begin
          running_sum <= running_sum - scl_pkg::SUM_W'(old_seg) + scl_pkg::SUM_W'(seg);
        end else begin
          running_sum <= running_sum + scl_pkg::SUM_W'(seg);
        end
        ring_pointer <= (ptr_inc >= ring_len) ? '0 : ptr_inc[scl_pkg::PTR_W-1:0];
      end
      if (cmd.finish) begin
        fill_count      <= fill_next;
        previous_sample <= cur_sample;
      end
    end
  end

  // Segment ring: read in the difference step, written in the update step
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      old_seg <= segment_ring[ptr_eff];
    end
    if (cmd.update) begin
      segment_ring[ptr_eff] <= seg;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_sample <= s_tdata;
    end
    if (cmd.diff) begin
      abs_diff <= diff[scl_pkg::DIFF_W-1] ? (scl_pkg::DIFF_W)'(-diff) : diff;
    end
    if (cmd.finish) begin
      m_tdata <= win_ready ? running_sum : '0;
      m_tuser <= win_ready;
    end
  end

endmodule

/* hdl/scl_ctrl.sv */
module scl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  scl_pkg::status_t  status,
  output scl_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIFF = 6'b000010,
    S_SQ   = 6'b000100,
    S_ROOT = 6'b001000,
    S_UPD  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          // first sample after restart forms no segment
          state_next  = status.first ? S_FIN : S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_ROOT;
      end
      S_ROOT: begin
        if (status.sqrt_done) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/sliding_curve_length.sv */
// Sliding curve-length transform for a filtered ECG stream.
// Input channel s_*: one signed 16-bit sample per request.
// Output channel m_*: one result per request; m_tdata is the sum of the
//   segment lengths over the last window_len-1 segments, m_tuser is the
//   ready flag (high once window_len samples have arrived, else data is 0).
// Config port: cfg_we/cfg_index/cfg_data, index 0 window_len (clamped to
//   2..64, restarts the window), index 1 time_step_sq. Write only when idle.
// A normal sample passes the difference, root start, root, update and final
//   steps before m_tvalid, the root being the 18-step bit-serial square root;
//   the first sample of a window goes straight to the final step. s_tready
//   is high only while the controller is idle: one sample is in work at a time.
// A finished result sits in the output register, so the next sample is
//   accepted while the receiver stalls; a second result then waits in the
//   final step until the output register is free.
// Reset (rst, synchronous): window_len 33, time_step_sq 0, window cleared,
//   no result pending. The segment ring needs no clearing.
module sliding_curve_length (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [scl_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [scl_pkg::SUM_W-1:0]     m_tdata,   // [23:0] curve_length
  output logic                          m_tuser,   // [0] ready_res
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [scl_pkg::TSQ_W-1:0]     cfg_data
);

  scl_pkg::cmd_t    cmd;
  scl_pkg::status_t status;

  scl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  scl_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

/* hdl/scl_checker.sv */
module scl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [scl_pkg::SUM_W-1:0]     m_tdata,
  input logic                          m_tuser
);

  // one sample in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("sample accepted while previous one in work");

  // not-ready results carry a zero length
  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("nonzero length before window is full");

  // no result without work: after reset nothing is offered
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("block not idle after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind sliding_curve_length scl_checker u_scl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* verif/sliding_curve_length_test.sv */
`timescale 1ns / 1ps

// Sliding curve-length transform testbench.
// A clocked driver feeds samples from a queue and a clocked monitor checks each
// result against a software model of the window kept here. Configuration
// writes only happen once the block has gone quiet.
module sliding_curve_length_test;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 40;     // margin beyond one sample's pass through the block
  localparam int unsigned TARGET_ITEMS = 1100;

  typedef struct packed {
    logic [scl_pkg::SUM_W-1:0] curve_length;
    logic                      ready_res;
  } curve_result_t;

  // DUT ports, all inputs known from time zero
  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         s_tvalid  = 1'b0;
  logic                         s_tready;
  logic [scl_pkg::SAMPLE_W-1:0] s_tdata   = '0;   // [15:0] sample
  logic                         m_tvalid;
  logic                         m_tready  = 1'b0;
  logic [scl_pkg::SUM_W-1:0]    m_tdata;          // [23:0] curve_length
  logic                         m_tuser;          // [0] ready_res
  logic                         cfg_we    = 1'b0;
  logic                         cfg_index = 1'b0;
  logic [scl_pkg::TSQ_W-1:0]    cfg_data  = '0;

  // Samples waiting to be requested, results owed by the block
  logic [scl_pkg::SAMPLE_W-1:0] sample_queue[$];
  curve_result_t                length_due[$];

  int          fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned items_queued  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          walk_level    = 0;

  // Window model state
  int unsigned                         win_len     = 33;
  logic [scl_pkg::TSQ_W-1:0]           step_sq     = '0;
  logic signed [scl_pkg::SAMPLE_W-1:0] last_sample = '0;
  logic [scl_pkg::SEG_W-1:0]           seg_hist[0:scl_pkg::RING_DEPTH-1];
  logic [scl_pkg::SUM_W-1:0]           window_sum  = '0;
  int unsigned                         hist_ptr    = 0;
  int unsigned                         fill_cnt    = 0;

  sliding_curve_length uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // floor(sqrt(v)), greedy from the top root bit down
  function automatic logic [scl_pkg::SEG_W-1:0] root_floor(logic [63:0] v);
    logic [scl_pkg::SEG_W-1:0] r;
    logic [scl_pkg::SEG_W-1:0] t;
    r = '0;
    for (int b = scl_pkg::SEG_W - 1; b >= 0; b--) begin
      t = r | (scl_pkg::SEG_W'(1) << b);
      if (64'(t) * 64'(t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic int unsigned clamp_len(logic [scl_pkg::WIN_W-1:0] v);
    if (v < scl_pkg::WIN_MIN) return scl_pkg::WIN_MIN;
    if (v > scl_pkg::WIN_MAX) return scl_pkg::WIN_MAX;
    return v;
  endfunction

  // Advance the window model by one sample and return the result it owes.
  task automatic predict_curve_length(input logic [scl_pkg::SAMPLE_W-1:0] smp,
                                      output curve_result_t res);
    int                        diff;
    logic [63:0]               mag;
    logic [scl_pkg::SEG_W-1:0] seg;
    int unsigned               span;
    span = win_len - 1;
    // the first sample of a window forms no segment; it primes last_sample and the fill count
    if (fill_cnt > 0) begin
      diff = int'($signed(smp)) - int'(last_sample);
      mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
      seg  = root_floor(64'(step_sq) + mag * mag);
      if (hist_ptr >= span) hist_ptr = 0;
      // oldest segment drops out only once the ring is full
      if (fill_cnt >= win_len) window_sum -= scl_pkg::SUM_W'(seg_hist[hist_ptr]);
      seg_hist[hist_ptr] = seg;
      window_sum += scl_pkg::SUM_W'(seg);
      hist_ptr = (hist_ptr + 1 >= span) ? 0 : hist_ptr + 1;
    end
    if (fill_cnt < win_len) fill_cnt++;
    last_sample = $signed(smp);
    res.ready_res    = (fill_cnt >= win_len);
    res.curve_length = res.ready_res ? window_sum : '0;
  endtask

  // Register write; the model follows at once since the block is idle.
  task automatic write_reg(input logic idx, input logic [scl_pkg::TSQ_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == scl_pkg::CFG_WINDOW_LEN) begin
      // window restart: next sample is a first sample again
      win_len     = clamp_len(value[scl_pkg::WIN_W-1:0]);
      last_sample = '0;
      window_sum  = '0;
      hist_ptr    = 0;
      fill_cnt    = 0;
    end else begin
      step_sq = value;
    end
  endtask

  // Upper data bits are junk; only the low seven bits count.
  task automatic set_window(input logic [scl_pkg::WIN_W-1:0] wl);
    logic [scl_pkg::TSQ_W-1:0] v;
    v = scl_pkg::TSQ_W'({$urandom, $urandom});
    v[scl_pkg::WIN_W-1:0] = wl;
    write_reg(scl_pkg::CFG_WINDOW_LEN, v);
  endtask

  task automatic queue_sample(input logic [scl_pkg::SAMPLE_W-1:0] v);
    sample_queue = {sample_queue, v};
    items_queued++;
  endtask

  // Wait for the block to drain: nothing queued, no request up, nothing owed, then the DRAIN_CYCLES margin.
  // Checked on the falling edge so the driver's updates have settled.
  task automatic settle();
    while (sample_queue.size() != 0 || length_due.size() != 0 || s_tvalid)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Idle pattern by progress: sender-light, receiver-light, then none.
  task automatic set_idle();
    if (items_queued < 440) begin
      send_idle_pct = 38;
      recv_idle_pct = 62;
    end else if (items_queued < 880) begin
      send_idle_pct = 62;
      recv_idle_pct = 38;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  function automatic logic [scl_pkg::SAMPLE_W-1:0] next_sample(int unsigned profile);
    case (profile)
      0: return scl_pkg::SAMPLE_W'($urandom);
      1: begin
        // slow ECG-like drift
        walk_level += int'($urandom_range(0, 400)) - 200;
        if (walk_level > 32767) walk_level = 32767;
        if (walk_level < -32768) walk_level = -32768;
        return scl_pkg::SAMPLE_W'(walk_level);
      end
      2: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'hFFFF;
          default: return scl_pkg::SAMPLE_W'($urandom);
        endcase
      end
      default: begin
        // drift with the odd QRS-sized jump
        if ($urandom_range(0, 7) == 0)
          walk_level = int'($signed(scl_pkg::SAMPLE_W'($urandom)));
        else walk_level += int'($urandom_range(0, 2000)) - 1000;
        if (walk_level > 32767) walk_level = 32767;
        if (walk_level < -32768) walk_level = -32768;
        return scl_pkg::SAMPLE_W'(walk_level);
      end
    endcase
  endfunction

  function automatic logic [scl_pkg::TSQ_W-1:0] pick_step_sq();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return scl_pkg::TSQ_W'($urandom_range(0, 4096));
      3: return scl_pkg::TSQ_W'($urandom_range(0, 1 << 20));
      default: return scl_pkg::TSQ_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [scl_pkg::WIN_W-1:0] pick_window();
    case ($urandom_range(0, 9))
      0: return scl_pkg::WIN_MIN;
      1: return scl_pkg::WIN_MAX;
      2: begin
        // out of range both ways, clamped by the block
        if ($urandom_range(0, 1) == 0) return scl_pkg::WIN_W'($urandom_range(0, 1));
        return scl_pkg::WIN_W'($urandom_range(65, 127));
      end
      3, 4, 5, 6: return scl_pkg::WIN_W'($urandom_range(2, 12));
      default: return scl_pkg::WIN_W'($urandom_range(13, 64));
    endcase
  endfunction

  // Driver: the model advances on every accepted request.
  always @(posedge clk) begin : drive
    curve_result_t res;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_curve_length(s_tdata, res);
        length_due = {length_due, res};
      end
      if (!s_tvalid || s_tready) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata  <= sample_queue.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each accepted result against the oldest owed one.
  always @(posedge clk) begin : observe
    curve_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (length_due.size() == 0) begin
        $error("unexpected result: curve_length %0d ready_res %0d", m_tdata, m_tuser);
        fail_count++;
      end else begin
        want = length_due.pop_front();
        if (m_tdata !== want.curve_length) begin
          $error("curve_length mismatch: expected %0d, actual %0d",
                 want.curve_length, m_tdata);
          fail_count++;
        end
        if (m_tuser !== want.ready_res) begin
          $error("ready_res mismatch: expected %0d, actual %0d", want.ready_res, m_tuser);
          fail_count++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : main
    int unsigned               phase;
    int unsigned               n;
    int unsigned               profile;
    int unsigned               mode;
    logic [scl_pkg::WIN_W-1:0] wl;
    for (int i = 0; i < scl_pkg::RING_DEPTH; i++) seg_hist[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_idle();

    // Reset values: window 33, so nothing is ready yet
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    queue_sample(16'h0000);
    settle();

    // Window below range clamps to 2; full-scale swings, flat segment, +-1
    set_window(scl_pkg::WIN_W'(0));
    write_reg(scl_pkg::CFG_TIME_STEP_SQ, '0);
    queue_sample(16'h8000);
    queue_sample(16'h7FFF);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    queue_sample(16'h0000);
    queue_sample(16'hFFFF);
    queue_sample(16'h0001);
    settle();

    // Largest radicand: max time step with full-scale differences
    set_window(scl_pkg::WIN_W'(3));
    write_reg(scl_pkg::CFG_TIME_STEP_SQ, '1);
    queue_sample(16'h8000);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    queue_sample(16'h7FFF);
    queue_sample(16'h0005);
    settle();

    // Time step changed mid-window: only later segments see it
    write_reg(scl_pkg::CFG_TIME_STEP_SQ, scl_pkg::TSQ_W'(12345));
    queue_sample(16'h0000);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    settle();

    // Random phases, the first few at fixed corners
    phase = 0;
    while (items_queued < TARGET_ITEMS) begin
      case (phase)
        0: begin
          set_window(scl_pkg::WIN_RESET);
          write_reg(scl_pkg::CFG_TIME_STEP_SQ, '0);
        end
        1: begin
          set_window(scl_pkg::WIN_MAX);
          write_reg(scl_pkg::CFG_TIME_STEP_SQ, '1);
        end
        2: begin
          set_window(scl_pkg::WIN_MIN);
          write_reg(scl_pkg::CFG_TIME_STEP_SQ, '1);
        end
        3: begin
          set_window(scl_pkg::WIN_W'(127));
          write_reg(scl_pkg::CFG_TIME_STEP_SQ, pick_step_sq());
        end
        4: begin
          set_window(scl_pkg::WIN_W'(1));
          write_reg(scl_pkg::CFG_TIME_STEP_SQ, '0);
        end
        default: begin
          mode = $urandom_range(0, 2);
          wl   = pick_window();
          if (mode != 2) set_window(wl);
          if (mode != 1) write_reg(scl_pkg::CFG_TIME_STEP_SQ, pick_step_sq());
        end
      endcase
      set_idle();
      profile = $urandom_range(0, 3);
      n = win_len + $urandom_range(5, 60);
      for (int i = 0; i < n; i++) queue_sample(next_sample(profile));
      settle();
      phase++;
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
